// ===== hdl/tmvd_pkg.sv =====
`default_nettype none
package tmvd_pkg;

  localparam int NUM_TILES = 64;
  localparam int TILE_W    = $clog2(NUM_TILES);
  localparam int VALUE_W   = 16;
  localparam int NUM_FEAT  = 5;
  localparam int CNT_W     = 13;
  localparam int SUM_W     = VALUE_W + 14;
  localparam int PROD_W    = VALUE_W + CNT_W + 1;
  localparam int DIFF_W    = SUM_W + 2;
  localparam int THR_W     = 9;
  localparam int LIMIT_W   = THR_W + 1 + CNT_W;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 3;
  localparam int VOTE_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARMUP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART   = 2'd2;

  localparam logic [THR_W-1:0] THRESHOLD_RST = 9'd144;
  localparam logic [CNT_W-1:0] WARMUP_RST    = 13'd50;
  localparam logic [CNT_W-1:0] RESTART_RST   = 13'd5000;

  // Last vote step: steps run one per feature plus one to drain the multiplier.
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_FEAT);

  typedef logic [NUM_FEAT-1:0][VALUE_W-1:0] feat_vec_t;
  typedef logic [NUM_FEAT-1:0][SUM_W-1:0]   sum_row_t;

  typedef struct packed {
    logic              load;
    logic              calc;
    logic              vote;
    logic [STEP_W-1:0] step;
    logic              finish;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/tmvd_ctrl.sv =====
`default_nettype none
module tmvd_ctrl
  import tmvd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire logic    restart_i,
  output logic         busy_o,
  output dp_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_VOTE = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        step_d  = '0;
        state_d = restart_i ? ST_DONE : ST_VOTE;
      end
      ST_VOTE: begin
        if (step_q == LAST_STEP) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign cmd_o.load    = (state_q == ST_IDLE) && start_i;
  assign cmd_o.calc    = (state_q == ST_CALC);
  assign cmd_o.vote    = (state_q == ST_VOTE);
  assign cmd_o.step    = step_q;
  assign cmd_o.finish  = (state_q == ST_DONE);

endmodule
`default_nettype wire

// ===== hdl/tmvd_datapath.sv =====
`default_nettype none
module tmvd_datapath
  import tmvd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire dp_cmd_t           cmd_i,
  input  wire logic [TILE_W-1:0] tile_i,
  input  wire feat_vec_t         feats_i,
  input  wire logic [THR_W-1:0]  threshold_i,
  input  wire logic [CNT_W-1:0]  warmup_i,
  input  wire logic [CNT_W-1:0]  period_i,
  output logic                   restart_o,
  output logic                   result_valid_o,
  output logic [TILE_W-1:0]      tile_out_o,
  output logic                   motion_o,
  output logic [VOTE_W-1:0]      vote_count_o
);

  // Per-tile history. A tile whose valid bit is clear reads as all zero.
  logic [CNT_W-1:0] cnt_mem [NUM_TILES];
  sum_row_t         sum_mem [NUM_TILES];
  logic [NUM_TILES-1:0] valid_q;

  logic [TILE_W-1:0] tile_q;
  feat_vec_t         feats_q;
  logic [CNT_W-1:0]  rd_cnt_q;
  sum_row_t          rd_sum_q;
  logic              rd_valid_q;

  logic [CNT_W:0]    n_d;
  logic [CNT_W-1:0]  cnt_old;
  sum_row_t          sum_new;
  logic [LIMIT_W-1:0] limit_d;

  logic [CNT_W-1:0]   n_q;
  sum_row_t           sum_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               warm_q;
  logic               restart_q;

  logic signed [VALUE_W-1:0] feat_sel;
  logic signed [SUM_W-1:0]   sum_sel;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_abs;
  logic                      vote_hit;
  logic [VOTE_W-1:0]         votes_q;

  logic              out_valid_q;
  logic [TILE_W-1:0] out_tile_q;
  logic [VOTE_W-1:0] out_votes_q;

  // Input capture and registered memory read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tile_q     <= tile_i;
      feats_q    <= feats_i;
      rd_cnt_q   <= cnt_mem[tile_i];
      rd_sum_q   <= sum_mem[tile_i];
      rd_valid_q <= valid_q[tile_i];
    end
  end

  always_comb begin
    cnt_old = rd_valid_q ? rd_cnt_q : '0;
    n_d     = {1'b0, cnt_old} + 1'b1;
    for (int k = 0; k < NUM_FEAT; k++) begin
      sum_new[k] = (rd_valid_q ? rd_sum_q[k] : '0)
                 + {{(SUM_W-VALUE_W){feats_q[k][VALUE_W-1]}}, feats_q[k]};
    end
    limit_d   = LIMIT_W'({threshold_i, 1'b0}) * LIMIT_W'(n_d[CNT_W-1:0]);
    restart_o = (n_d >= {1'b0, period_i}) || n_d[CNT_W];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      n_q       <= n_d[CNT_W-1:0];
      sum_q     <= sum_new;
      limit_q   <= limit_d;
      warm_q    <= (n_d > {1'b0, warmup_i});
      restart_q <= restart_o;
      if (!restart_o) begin
        cnt_mem[tile_q] <= n_d[CNT_W-1:0];
        sum_mem[tile_q] <= sum_new;
      end
    end
  end

  // A restart drops the tile's valid bit, which reads back as a cleared history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.calc) begin
      valid_q[tile_q] <= !restart_o;
    end
  end

  // Vote steps are pipelined: step k multiplies feature k, step k+1 compares it.
  always_comb begin
    case (cmd_i.step)
      3'd0:    feat_sel = $signed(feats_q[0]);
      3'd1:    feat_sel = $signed(feats_q[1]);
      3'd2:    feat_sel = $signed(feats_q[2]);
      3'd3:    feat_sel = $signed(feats_q[3]);
      3'd4:    feat_sel = $signed(feats_q[4]);
      default: feat_sel = '0;
    endcase
    case (cmd_i.step)
      3'd1:    sum_sel = $signed(sum_q[0]);
      3'd2:    sum_sel = $signed(sum_q[1]);
      3'd3:    sum_sel = $signed(sum_q[2]);
      3'd4:    sum_sel = $signed(sum_q[3]);
      3'd5:    sum_sel = $signed(sum_q[4]);
      default: sum_sel = '0;
    endcase
    prod_d   = PROD_W'(feat_sel) * PROD_W'($signed({1'b0, n_q}));
    diff     = {{(DIFF_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}
             - {{(DIFF_W-SUM_W){sum_sel[SUM_W-1]}}, sum_sel};
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    vote_hit = warm_q && (cmd_i.step != 3'd0)
            && (diff_abs > {{(DIFF_W-LIMIT_W){1'b0}}, limit_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.vote) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      votes_q <= '0;
    end else if (cmd_i.calc) begin
      votes_q <= '0;
    end else if (cmd_i.vote && vote_hit) begin
      votes_q <= votes_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_tile_q  <= tile_q;
      out_votes_q <= restart_q ? '0 : votes_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign tile_out_o     = out_tile_q;
  assign vote_count_o   = out_votes_q;
  assign motion_o       = (out_votes_q > 3'd2);

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_votes_q <= 3'd5))
    else $error("vote count above the number of features");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && restart_q) |=> (out_valid_q && out_votes_q == 3'd0))
    else $error("restarted tile reported votes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && !warm_q) |=> (out_votes_q == 3'd0))
    else $error("tile voted during warm-up");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.calc |=> (votes_q == 3'd0))
    else $error("vote counter not cleared for a new transaction");
`endif

endmodule
`default_nettype wire

// ===== hdl/tile_motion_vote_detector.sv =====
// An accepted transaction runs the calc state, the vote steps and the done state; a
// restarting tile skips the vote steps. One shared multiplier walks the five features
// in turn. A new transaction is accepted only while idle, so transactions never overlap.
// The receiver cannot stall; each result is flagged valid for one cycle only.
// Reset is asynchronous and active low; it restores the register defaults and clears
// every tile's history at once through per-tile valid bits, with no clearing pass.
`default_nettype none
module tile_motion_vote_detector
  import tmvd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [TILE_W-1:0]    tile_index_i,
  input  wire logic [VALUE_W-1:0]   mean_feature_i,
  input  wire logic [VALUE_W-1:0]   sigma_feature_i,
  input  wire logic [VALUE_W-1:0]   horizontal_feature_i,
  input  wire logic [VALUE_W-1:0]   vertical_feature_i,
  input  wire logic [VALUE_W-1:0]   diagonal_feature_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                      result_valid_o,
  output logic [TILE_W-1:0]         tile_out_o,
  output logic                      motion_o,
  output logic [VOTE_W-1:0]         vote_count_o
);

  logic [THR_W-1:0] threshold_q;
  logic [CNT_W-1:0] warmup_q;
  logic [CNT_W-1:0] period_q;

  dp_cmd_t   cmd;
  logic      restart;
  logic      busy;
  feat_vec_t feats;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RST;
      warmup_q    <= WARMUP_RST;
      period_q    <= RESTART_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_THRESHOLD: threshold_q <= cfg_wdata_i[THR_W-1:0];
        REG_WARMUP:    warmup_q    <= cfg_wdata_i;
        REG_RESTART:   period_q    <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  assign feats[0] = mean_feature_i;
  assign feats[1] = sigma_feature_i;
  assign feats[2] = horizontal_feature_i;
  assign feats[3] = vertical_feature_i;
  assign feats[4] = diagonal_feature_i;

  tmvd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .restart_i (restart),
    .busy_o    (busy),
    .cmd_o     (cmd)
  );

  tmvd_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .tile_i         (tile_index_i),
    .feats_i        (feats),
    .threshold_i    (threshold_q),
    .warmup_i       (warmup_q),
    .period_i       (period_q),
    .restart_o      (restart),
    .result_valid_o (result_valid_o),
    .tile_out_o     (tile_out_o),
    .motion_o       (motion_o),
    .vote_count_o   (vote_count_o)
  );

  assign busy_o = busy;

endmodule
`default_nettype wire
